// ===== design/qslerp_pkg.sv =====
// Package with shared constants and the arctangent table for the slerp pipeline.
`default_nettype none
package qslerp_pkg;
    localparam int FRAC_BITS_DEF = 15;
    localparam int ANG_BITS      = 30;
    localparam int CORDIC_STEPS  = 30;
    localparam int AW            = 34;
    localparam logic signed [AW-1:0] INV_GAIN = 34'sd652032874;
    localparam logic [15:0] THR_RESET = 16'd3;

    function automatic logic signed [AW-1:0] atan_tab(input logic [4:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0: v = 34'sd843314857;
            5'd1: v = 34'sd497837829;
            5'd2: v = 34'sd263043837;
            5'd3: v = 34'sd133525159;
            5'd4: v = 34'sd67021687;
            5'd5: v = 34'sd33543516;
            5'd6: v = 34'sd16775851;
            5'd7: v = 34'sd8388437;
            5'd8: v = 34'sd4194283;
            5'd9: v = 34'sd2097149;
            default: v = AW'(64'sd1 <<< (30 - i));
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== design/quaternion_slerp_top.sv =====
// Top level of the fixed-point quaternion slerp pipeline.
// Usage: one item enters on the s_axis channel per transfer, carrying start and
// end quaternions and a blend factor. One result leaves on m_axis per item.
// Configuration writes of linear_threshold arrive on the cfg channel, taken only
// while the pipeline is empty and no input transfer is offered.
// Throughput is one item per cycle while the receiver does not stall. The pipeline
// has 98 register stages at FRAC_BITS 15: three front stages, 16 square-root
// stages, two 30-step CORDIC chains (one step per stage), 17 restoring divider
// stages (one quotient bit per stage) and two output stages.
// The whole pipeline advances only when the output register is free or taken,
// so a stall of the receiver holds every stage and nothing is lost.
// Reset clears all valid bits and sets the threshold to 3.
`default_nettype none
module quaternion_slerp_top #(
    parameter int FRAC_BITS = qslerp_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w, blend
    input  wire logic [143:0] s_axis_tdata,
    input  wire logic         i_cfg_valid,
    output      logic         o_cfg_ready,
    input  wire logic [15:0]  i_cfg_data,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_x, out_y, out_z, out_w
    output      logic [63:0]  m_axis_tdata,
    // used_linear
    output      logic         m_axis_tuser
);
    import qslerp_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int ONE = 1 << F;
    localparam int UP  = ANG_BITS - F;
    localparam int NSQ = F + 1;             // square-root result bits
    localparam int NDV = F + 2;             // quotient bits, weight <= 2^(F+1)
    localparam int NS  = 3 + NSQ + CORDIC_STEPS + CORDIC_STEPS + NDV + 2;
    localparam int WW  = F + 3;             // signed weight width
    localparam int IW  = (2*F+5 > 35) ? 2*F+5 : 35;   // inner product width
    localparam int GW  = IW + 1;

    typedef struct packed {
        logic signed [3:0][15:0] qa;
        logic signed [3:0][16:0] qb;       // one bit more, the fold may negate -1.0
        logic [F:0]              t;
        logic                    lin;
        logic signed [IW-1:0]    inner;
        logic [2*F+1:0]          rad;      // remainder / sqrt radicand
        logic [NSQ-1:0]          root;
        logic signed [AW-1:0]    vx, vy, az;   // CORDIC vectoring
        logic signed [AW-1:0]    ang;
        logic signed [AW-1:0]    ax, ay, aa;   // sine of (1-t)w
        logic signed [AW-1:0]    bx, by, ba;   // sine of tw
        logic [AW+F:0]           na, nb;       // dividend remainders
        logic [NDV-1:0]          wa, wb;       // quotients
        logic signed [WW-1:0]    ka, kb;       // final weights
        logic signed [3:0][15:0] res;
    } t_stage;

    logic [15:0] r_thr;
    t_stage      r_st [NS];
    logic [NS-1:0] r_v;
    logic        adv;

    assign adv           = !r_v[NS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign o_cfg_ready   = !(|r_v) && !s_axis_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thr <= THR_RESET;
        else if (i_cfg_valid && o_cfg_ready) r_thr <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-2:0], s_axis_tvalid};
    end

    // Stage functions are chosen by the stage index; each is a shallow step.
    function automatic logic signed [AW-1:0] fshr(input logic signed [AW-1:0] v,
                                                  input int s);
        return v >>> s;
    endfunction

    for (genvar g = 0; g < NS; g++) begin : g_stage
        t_stage n_st;
        always_comb begin
            t_stage p;
            logic [2*F+1:0] trial;
            logic [AW+F:0]  den;
            logic signed [AW-1:0] dx, dy;
            logic signed [GW-1:0] gap;
            logic signed [2*F+WW+2:0] acc;
            logic signed [32:0] prod;
            logic signed [WW+16:0] pa, pb;
            logic [F:0] cf;
            int i;
            n_st = '0;
            p = '0;
            trial = '0; den = '0; dx = '0; dy = '0;
            gap = '0; acc = '0; prod = '0; pa = '0; pb = '0; cf = '0; i = 0;
            if (g == 0) begin
                for (int k = 0; k < 4; k++) begin
                    p.qa[k] = s_axis_tdata[16*k +: 16];
                    p.qb[k] = {s_axis_tdata[64+16*k+15], s_axis_tdata[64+16*k +: 16]};
                end
                p.t = (32'(s_axis_tdata[143:128]) > 32'(ONE)) ? (F+1)'(ONE)
                                                              : (F+1)'(s_axis_tdata[143:128]);
                n_st = p;
            end else begin
                p = r_st[(g == 0) ? 0 : g - 1];
                n_st = p;
                if (g == 1) begin
                    n_st.inner = '0;
                    for (int k = 0; k < 4; k++) begin
                        prod = 33'($signed(p.qa[k])) * 33'($signed(p.qb[k]));
                        n_st.inner = n_st.inner + IW'(prod);
                    end
                end else if (g == 2) begin
                    if (p.inner < 0) begin
                        n_st.inner = -p.inner;
                        for (int k = 0; k < 4; k++) n_st.qb[k] = -p.qb[k];
                    end
                    gap = (GW'(1) <<< (2*F)) - GW'(n_st.inner);
                    n_st.lin = !(gap > $signed({1'b0, IW'(r_thr) << F}));
                    // radicand 1 - c*c with c = floor(inner / one)
                    cf = (F+1)'(n_st.inner >>> F);
                    n_st.rad = ((2*F+2)'(1) << (2*F)) - (2*F+2)'(cf) * (2*F+2)'(cf);
                    n_st.root = '0;
                end else if (g < 3 + NSQ) begin
                    i = NSQ - 1 - (g - 3);
                    trial = (2*F+2)'((64'(p.root) << (i + 1)) + (64'd1 << (2*i)));
                    if (p.rad >= trial) begin
                        n_st.rad  = p.rad - trial;
                        n_st.root = p.root | NSQ'(1 << i);
                    end
                    if (g == 2 + NSQ) begin
                        n_st.vx = AW'((p.inner >>> F)) <<< UP;
                        n_st.vy = AW'(n_st.root) <<< UP;
                        n_st.az = '0;
                    end
                end else if (g < 3 + NSQ + CORDIC_STEPS) begin
                    i = g - 3 - NSQ;
                    dx = fshr(p.vy, i); dy = fshr(p.vx, i);
                    if (p.vy > 0) begin
                        n_st.vx = p.vx + dx; n_st.vy = p.vy - dy;
                        n_st.az = p.az + atan_tab(5'(i));
                    end else begin
                        n_st.vx = p.vx - dx; n_st.vy = p.vy + dy;
                        n_st.az = p.az - atan_tab(5'(i));
                    end
                    if (i == CORDIC_STEPS - 1) begin
                        n_st.ang = (n_st.az < 0) ? '0 : n_st.az;
                        n_st.aa = AW'(((AW+F+1)'(n_st.ang)
                                       * (AW+F+1)'((F+1)'(ONE) - p.t)) >> F);
                        n_st.ba = AW'(((AW+F+1)'(n_st.ang) * (AW+F+1)'(p.t)) >> F);
                        n_st.ax = INV_GAIN; n_st.ay = '0;
                        n_st.bx = INV_GAIN; n_st.by = '0;
                    end
                end else if (g < 3 + NSQ + 2*CORDIC_STEPS) begin
                    i = g - 3 - NSQ - CORDIC_STEPS;
                    dx = fshr(p.ay, i); dy = fshr(p.ax, i);
                    if (p.aa >= 0) begin
                        n_st.ax = p.ax - dx; n_st.ay = p.ay + dy;
                        n_st.aa = p.aa - atan_tab(5'(i));
                    end else begin
                        n_st.ax = p.ax + dx; n_st.ay = p.ay - dy;
                        n_st.aa = p.aa + atan_tab(5'(i));
                    end
                    dx = fshr(p.by, i); dy = fshr(p.bx, i);
                    if (p.ba >= 0) begin
                        n_st.bx = p.bx - dx; n_st.by = p.by + dy;
                        n_st.ba = p.ba - atan_tab(5'(i));
                    end else begin
                        n_st.bx = p.bx + dx; n_st.by = p.by - dy;
                        n_st.ba = p.ba + atan_tab(5'(i));
                    end
                    if (i == CORDIC_STEPS - 1) begin
                        // Clamp sines to [0, 1] and load the dividends.
                        if (n_st.ay < 0) n_st.ay = '0;
                        if (n_st.ay > (AW'(1) <<< ANG_BITS)) n_st.ay = AW'(1) <<< ANG_BITS;
                        if (n_st.by < 0) n_st.by = '0;
                        if (n_st.by > (AW'(1) <<< ANG_BITS)) n_st.by = AW'(1) <<< ANG_BITS;
                        n_st.na = (AW+F+1)'(n_st.ay) << F;
                        n_st.nb = (AW+F+1)'(n_st.by) << F;
                        n_st.wa = '0; n_st.wb = '0;
                    end
                end else if (g < 3 + NSQ + 2*CORDIC_STEPS + NDV) begin
                    // Restoring division, one quotient bit per stage.
                    i = NDV - 1 - (g - 3 - NSQ - 2*CORDIC_STEPS);
                    den = (AW+F+1)'(p.root) << (UP + i);
                    if (p.na >= den) begin
                        n_st.na = p.na - den; n_st.wa[i] = 1'b1;
                    end
                    if (p.nb >= den) begin
                        n_st.nb = p.nb - den; n_st.wb[i] = 1'b1;
                    end
                end else if (g == NS - 2) begin
                    if (p.lin) begin
                        n_st.ka = WW'((F+1)'(ONE) - p.t);
                        n_st.kb = WW'(p.t);
                    end else begin
                        n_st.ka = WW'(p.wa);
                        n_st.kb = WW'(p.wb);
                    end
                end else begin
                    for (int k = 0; k < 4; k++) begin
                        pa = (WW+17)'(p.ka) * (WW+17)'($signed(p.qa[k]));
                        pb = (WW+17)'(p.kb) * (WW+17)'($signed(p.qb[k]));
                        acc = (2*F+WW+3)'(pa) + (2*F+WW+3)'(pb)
                            + (2*F+WW+3)'(1 << (F - 1));
                        acc = acc >>> F;
                        if (acc > 32767) n_st.res[k] = 16'sh7fff;
                        else if (acc < -32768) n_st.res[k] = 16'sh8000;
                        else n_st.res[k] = acc[15:0];
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_st[g] <= n_st;
        end
    end

    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = r_st[NS-1].res;
    assign m_axis_tuser  = r_st[NS-1].lin;
endmodule
`default_nettype wire

// ===== design/qslerp_checker.sv =====
// Port-level checker for the slerp block, bound to the top level.
`default_nettype none
module qslerp_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [63:0]  m_axis_tdata,
    input wire logic         m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the pipeline is stalled");
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused with empty output");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind quaternion_slerp_top qslerp_checker u_chk (.*);
`default_nettype wire
